// ----- hw/rtl/semt_pkg.sv -----
// ----------------------------------------------------------------------------
// semt_pkg
// shared widths, register indexes and mode codes of the bitmap touch decoder
// ----------------------------------------------------------------------------
package semt_pkg;

   localparam int MAP_BITS_DEF = 32;
   localparam int MAP_W        = 32;
   localparam int COORD_W      = 16;
   localparam int CNT_W        = 6;
   localparam int MODE_W       = 2;
   localparam int FING_W       = 5;
   localparam int CORN_W       = 2;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int SQ_W         = 2 * COORD_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_RANGE_MAX  = 3'd0,
      CSR_Y_RANGE_MAX  = 3'd1,
      CSR_X_SENSOR_CNT = 3'd2,
      CSR_Y_SENSOR_CNT = 3'd3,
      CSR_MIRROR_MODE  = 3'd4
   } csr_idx_type;

   localparam logic [MODE_W-1:0] MIRROR_NONE = 2'd0;
   localparam logic [MODE_W-1:0] MIRROR_Y    = 2'd1;
   localparam logic [MODE_W-1:0] MIRROR_X    = 2'd2;

   localparam logic [COORD_W-1:0] X_RANGE_RST = 16'd4095;
   localparam logic [COORD_W-1:0] Y_RANGE_RST = 16'd4095;
   localparam logic [CNT_W-1:0]   X_CNT_RST   = 6'd15;
   localparam logic [CNT_W-1:0]   Y_CNT_RST   = 6'd11;
   localparam logic [CNT_W-1:0]   CNT_MIN     = 6'd2;

endpackage

// ----- hw/rtl/semt_req_if.sv -----
// ----------------------------------------------------------------------------
// semt_req_if
// input channel: two axis bitmaps, a restart flag and the first touch position
// ----------------------------------------------------------------------------
interface semt_req_if;
   import semt_pkg::*;

   logic               valid;
   logic               ready;
   logic [MAP_W-1:0]   x_bitmap;
   logic [MAP_W-1:0]   y_bitmap;
   logic [COORD_W-1:0] first_x;
   logic [COORD_W-1:0] first_y;
   logic               restart;

   modport source (output valid, x_bitmap, y_bitmap, first_x, first_y, restart,
                   input ready);
   modport sink   (input valid, x_bitmap, y_bitmap, first_x, first_y, restart,
                   output ready);
endinterface

// ----- hw/rtl/semt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// semt_rsp_if
// result channel: result flag, finger count and held second corner
// ----------------------------------------------------------------------------
interface semt_rsp_if;
   import semt_pkg::*;

   logic               valid;
   logic               ready;
   logic               valid_res;
   logic [FING_W-1:0]  finger_count;
   logic [COORD_W-1:0] second_x;
   logic [COORD_W-1:0] second_y;
   logic [CORN_W-1:0]  corner_index;

   modport source (output valid, valid_res, finger_count, second_x, second_y,
                   corner_index, input ready);
   modport sink   (input valid, valid_res, finger_count, second_x, second_y,
                   corner_index, output ready);
endinterface

// ----- hw/rtl/semt_scan.sv -----
// ----------------------------------------------------------------------------
// semt_scan
// bit-serial run tracker for one axis: first run and last run
// ----------------------------------------------------------------------------
module semt_scan #(
   parameter int MAP_BITS = semt_pkg::MAP_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          clear,
   input  logic                          shift,
   input  logic                          bit_in,
   input  logic [$clog2(MAP_BITS)-1:0]   pos,
   output logic [$clog2(MAP_BITS/2+1)-1:0] runs,
   output logic [$clog2(MAP_BITS)-1:0]   lo_start,
   output logic [$clog2(MAP_BITS+1)-1:0] lo_len,
   output logic [$clog2(MAP_BITS)-1:0]   hi_start,
   output logic [$clog2(MAP_BITS+1)-1:0] hi_len
);
   localparam int IW = $clog2(MAP_BITS);
   localparam int LW = $clog2(MAP_BITS+1);
   localparam int RW = $clog2(MAP_BITS/2+1);

   logic          prev_ff, prev_in;
   logic [RW-1:0] runs_ff, runs_in;
   logic [IW-1:0] los_ff, los_in, his_ff, his_in;
   logic [LW-1:0] lol_ff, lol_in, hil_ff, hil_in;
   logic [LW-1:0] half;

   always_comb begin
      prev_in = prev_ff;
      runs_in = runs_ff;
      los_in  = los_ff;
      lol_in  = lol_ff;
      his_in  = his_ff;
      hil_in  = hil_ff;
      if (clear) begin
         prev_in = 1'b0;
         runs_in = '0;
         los_in  = '0;
         lol_in  = '0;
         his_in  = '0;
         hil_in  = '0;
      end else if (shift) begin
         prev_in = bit_in;
         if (bit_in && !prev_ff) begin
            runs_in = runs_ff + RW'(1);
            if (runs_ff == '0) begin
               los_in = pos;
               lol_in = LW'(1);
            end else begin
               his_in = pos;
               hil_in = LW'(1);
            end
         end else if (bit_in) begin
            if (runs_ff == RW'(1)) lol_in = lol_ff + LW'(1);
            else                   hil_in = hil_ff + LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      runs_ff <= runs_in;
      los_ff  <= los_in;
      lol_ff  <= lol_in;
      his_ff  <= his_in;
      hil_ff  <= hil_in;
   end

   // a lone run is split into a low and a high half
   assign half     = lol_ff >> 1;
   assign runs     = runs_ff;
   assign lo_start = los_ff;
   assign lo_len   = (runs_ff == RW'(1)) ? lol_ff - half : lol_ff;
   assign hi_start = (runs_ff == RW'(1)) ? los_ff + IW'(half) : his_ff;
   assign hi_len   = (runs_ff == RW'(1)) ? ((half > LW'(1)) ? half : LW'(1)) : hil_ff;

endmodule

// ----- hw/rtl/semt_div.sv -----
// ----------------------------------------------------------------------------
// semt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module semt_div #(
   parameter int DVD_W = 23,
   parameter int DVS_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);
   localparam int CW = $clog2(DVD_W+1);

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in, rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   sh, diff;
   logic             ge;

   assign sh   = {rem_ff, quo_ff[DVD_W-1]};
   assign ge   = sh >= {1'b0, dvs_ff};
   assign diff = sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DVD_W - 1);
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hw/rtl/semi_mt_bitmap_two_touch.sv -----
// ----------------------------------------------------------------------------
// semi_mt_bitmap_two_touch
// sequence: scan of both bitmaps, four scalings (multiply, divider start,
//   quotient bits, done), corner search, load; the corner search is skipped
//   while a corner is held
// throughput: one item at a time, next beat taken the cycle after the load
// an empty bitmap on either axis skips the scan and goes straight to the load
// reset: registers to their documented values, no corner held
// ----------------------------------------------------------------------------
module semi_mt_bitmap_two_touch #(
   parameter int MAP_BITS = semt_pkg::MAP_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   semt_req_if.sink                           req,
   semt_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [semt_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [semt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import semt_pkg::*;

   localparam int IW    = $clog2(MAP_BITS);
   localparam int LW    = $clog2(MAP_BITS+1);
   localparam int RW    = $clog2(MAP_BITS/2+1);
   localparam int NW    = LW + 1;
   localparam int DW    = COORD_W + NW;
   localparam int DEN_W = CNT_W + 1;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_SCAN = 8'b00000010,
      S_MUL  = 8'b00000100,
      S_DIV  = 8'b00001000,
      S_SQX  = 8'b00010000,
      S_SQY  = 8'b00100000,
      S_CMP  = 8'b01000000,
      S_LOAD = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   logic [COORD_W-1:0] xmax_ff, ymax_ff;
   logic [CNT_W-1:0]   xcnt_ff, ycnt_ff;
   logic [MODE_W-1:0]  mode_ff;

   logic [MAP_BITS-1:0] xsh_ff, xsh_in, ysh_ff, ysh_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic [COORD_W-1:0]  fx_ff, fx_in, fy_ff, fy_in;
   logic                empty_ff, empty_in;
   logic                held_vld_ff, held_vld_in;
   logic [CORN_W-1:0]   held_idx_ff, held_idx_in;
   logic [1:0]          sel_ff, sel_in;
   logic [CORN_W-1:0]   ci_ff, ci_in, bidx_ff, bidx_in;
   logic [SQ_W:0]       best_ff, best_in;
   logic [SQ_W-1:0]     sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [DW-1:0]       num_ff, num_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic                go_ff, go_in;
   logic [COORD_W-1:0]  cxl_ff, cxh_ff, cyl_ff, cyh_ff;
   logic [COORD_W-1:0]  cxl_in, cxh_in, cyl_in, cyh_in;

   logic               rsp_vld_ff, rsp_vld_in;
   logic               ores_ff, ores_in;
   logic [FING_W-1:0]  ofing_ff, ofing_in;
   logic [COORD_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [CORN_W-1:0]  oidx_ff, oidx_in;

   logic [MAP_BITS-1:0] xm, ym;
   logic                scan_clr, scan_sh;
   logic [RW-1:0]       xruns, yruns;
   logic [IW-1:0]       xls, xhs, yls, yhs;
   logic [LW-1:0]       xll, xhl, yll, yhl;

   logic [COORD_W-1:0] mul_a, mul_b;
   logic [SQ_W-1:0]    prod;
   logic [IW-1:0]      k_start;
   logic [LW-1:0]      k_len;
   logic [NW-1:0]      k_val;
   logic [CNT_W-1:0]   cnt_sel, cnt_clamp;
   logic [COORD_W-1:0] max_sel;
   logic               div_done;
   logic [DW-1:0]      quo;
   logic [COORD_W-1:0] sat_v, mir_v;
   logic [COORD_W-1:0] ccx, ccy, adx, ady;
   logic [SQ_W:0]      sq_sum;
   logic [RW-1:0]      fing_max;
   logic [CORN_W-1:0]  pick;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         xmax_ff <= X_RANGE_RST;
         ymax_ff <= Y_RANGE_RST;
         xcnt_ff <= X_CNT_RST;
         ycnt_ff <= Y_CNT_RST;
         mode_ff <= MIRROR_NONE;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_X_RANGE_MAX:  xmax_ff <= csr_wdata;
            CSR_Y_RANGE_MAX:  ymax_ff <= csr_wdata;
            CSR_X_SENSOR_CNT: xcnt_ff <= csr_wdata[CNT_W-1:0];
            CSR_Y_SENSOR_CNT: ycnt_ff <= csr_wdata[CNT_W-1:0];
            CSR_MIRROR_MODE:  mode_ff <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- units
   semt_scan #(.MAP_BITS(MAP_BITS)) u_scan_x (
      .clock, .clear(scan_clr), .shift(scan_sh), .bit_in(xsh_ff[0]), .pos(pos_ff),
      .runs(xruns), .lo_start(xls), .lo_len(xll), .hi_start(xhs), .hi_len(xhl)
   );

   semt_scan #(.MAP_BITS(MAP_BITS)) u_scan_y (
      .clock, .clear(scan_clr), .shift(scan_sh), .bit_in(ysh_ff[0]), .pos(pos_ff),
      .runs(yruns), .lo_start(yls), .lo_len(yll), .hi_start(yhs), .hi_len(yhl)
   );

   semt_div #(.DVD_W(DW), .DVS_W(DEN_W)) u_div (
      .clock, .reset, .start(go_ff), .dividend(num_ff), .divisor(den_ff),
      .done(div_done), .quotient(quo)
   );

   // shared multiplier: scale numerator, then squared distances
   assign prod = mul_a * mul_b;

   assign xm = req.x_bitmap[MAP_BITS-1:0];
   assign ym = req.y_bitmap[MAP_BITS-1:0];

   // sel: bit 1 picks the y axis, bit 0 the high point
   assign k_start   = sel_ff[0] ? (sel_ff[1] ? yhs : xhs) : (sel_ff[1] ? yls : xls);
   assign k_len     = sel_ff[0] ? (sel_ff[1] ? yhl : xhl) : (sel_ff[1] ? yll : xll);
   assign k_val     = {k_start, 1'b0} + NW'(k_len) - NW'(1);
   assign cnt_sel   = sel_ff[1] ? ycnt_ff : xcnt_ff;
   assign cnt_clamp = (cnt_sel < CNT_MIN) ? CNT_MIN : cnt_sel;
   assign max_sel   = sel_ff[1] ? ymax_ff : xmax_ff;

   assign sat_v = (quo > DW'(max_sel)) ? max_sel : quo[COORD_W-1:0];
   assign mir_v = ((sel_ff[1] && mode_ff == MIRROR_Y) || (!sel_ff[1] && mode_ff == MIRROR_X))
                  ? max_sel - sat_v : sat_v;

   // corner 0 top-left, 1 top-right, 2 bottom-right, 3 bottom-left
   assign ccx    = (ci_ff == 2'd0 || ci_ff == 2'd3) ? cxl_ff : cxh_ff;
   assign ccy    = (ci_ff == 2'd0 || ci_ff == 2'd1) ? cyl_ff : cyh_ff;
   assign adx    = (fx_ff >= ccx) ? fx_ff - ccx : ccx - fx_ff;
   assign ady    = (fy_ff >= ccy) ? fy_ff - ccy : ccy - fy_ff;
   assign sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   assign fing_max = (xruns > yruns) ? xruns : yruns;
   assign pick     = (ci_ff == '0 || sq_sum < best_ff) ? ci_ff : bidx_ff;

   always_comb begin
      mul_a = xmax_ff;
      mul_b = '0;
      case (state_ff)
         S_MUL: begin
            mul_a = max_sel;
            mul_b = COORD_W'(k_val);
         end
         S_SQX: begin
            mul_a = adx;
            mul_b = adx;
         end
         S_SQY: begin
            mul_a = ady;
            mul_b = ady;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in    = state_ff;
      xsh_in      = xsh_ff;
      ysh_in      = ysh_ff;
      pos_in      = pos_ff;
      fx_in       = fx_ff;
      fy_in       = fy_ff;
      empty_in    = empty_ff;
      held_vld_in = held_vld_ff;
      held_idx_in = held_idx_ff;
      sel_in      = sel_ff;
      ci_in       = ci_ff;
      bidx_in     = bidx_ff;
      best_in     = best_ff;
      sqx_in      = sqx_ff;
      sqy_in      = sqy_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      go_in       = 1'b0;
      cxl_in      = cxl_ff;
      cxh_in      = cxh_ff;
      cyl_in      = cyl_ff;
      cyh_in      = cyh_ff;
      rsp_vld_in  = rsp_vld_ff;
      ores_in     = ores_ff;
      ofing_in    = ofing_ff;
      ox_in       = ox_ff;
      oy_in       = oy_ff;
      oidx_in     = oidx_ff;
      scan_clr    = 1'b0;
      scan_sh     = 1'b0;

      if (rsp_vld_ff && rsp.ready) rsp_vld_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               fx_in  = req.first_x;
               fy_in  = req.first_y;
               xsh_in = xm;
               ysh_in = ym;
               pos_in = '0;
               scan_clr = 1'b1;
               if (req.restart) held_vld_in = 1'b0;
               if (xm == '0 || ym == '0) begin
                  empty_in = 1'b1;
                  state_in = S_LOAD;
               end else begin
                  empty_in = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            scan_sh = 1'b1;
            xsh_in  = xsh_ff >> 1;
            ysh_in  = ysh_ff >> 1;
            pos_in  = pos_ff + IW'(1);
            if (pos_ff == IW'(MAP_BITS - 1)) begin
               sel_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            num_in   = prod[DW-1:0];
            den_in   = {cnt_clamp - CNT_W'(1), 1'b0};
            go_in    = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               case (sel_ff)
                  2'd0:    cxl_in = mir_v;
                  2'd1:    cxh_in = mir_v;
                  2'd2:    cyl_in = mir_v;
                  default: cyh_in = mir_v;
               endcase
               sel_in = sel_ff + 2'd1;
               if (sel_ff == 2'd3) begin
                  ci_in    = '0;
                  state_in = held_vld_ff ? S_LOAD : S_SQX;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_SQX: begin
            sqx_in   = prod;
            state_in = S_SQY;
         end
         S_SQY: begin
            sqy_in   = prod;
            state_in = S_CMP;
         end
         S_CMP: begin
            bidx_in = pick;
            if (ci_ff == '0 || sq_sum < best_ff) best_in = sq_sum;
            ci_in = ci_ff + CORN_W'(1);
            if (ci_ff == 2'd3) begin
               // hold the corner opposite the nearest one
               held_vld_in = 1'b1;
               held_idx_in = pick + CORN_W'(2);
               state_in    = S_LOAD;
            end else begin
               state_in = S_SQX;
            end
         end
         S_LOAD: begin
            // wait here while the previous result beat is still pending
            if (!rsp_vld_ff || rsp.ready) begin
               rsp_vld_in = 1'b1;
               if (empty_ff) begin
                  ores_in  = 1'b0;
                  ofing_in = '0;
                  ox_in    = '0;
                  oy_in    = '0;
                  oidx_in  = '0;
               end else begin
                  ores_in  = 1'b1;
                  ofing_in = FING_W'(fing_max);
                  ox_in    = (held_idx_ff == 2'd0 || held_idx_ff == 2'd3) ? cxl_ff : cxh_ff;
                  oy_in    = (held_idx_ff == 2'd0 || held_idx_ff == 2'd1) ? cyl_ff : cyh_ff;
                  oidx_in  = held_idx_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         held_vld_ff <= 1'b0;
         go_ff       <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         held_vld_ff <= held_vld_in;
         go_ff       <= go_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      held_idx_ff <= held_idx_in;
      empty_ff    <= empty_in;
      xsh_ff      <= xsh_in;
      ysh_ff      <= ysh_in;
      pos_ff      <= pos_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      sel_ff      <= sel_in;
      ci_ff       <= ci_in;
      bidx_ff     <= bidx_in;
      best_ff     <= best_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      cxl_ff      <= cxl_in;
      cxh_ff      <= cxh_in;
      cyl_ff      <= cyl_in;
      cyh_ff      <= cyh_in;
      ores_ff     <= ores_in;
      ofing_ff    <= ofing_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      oidx_ff     <= oidx_in;
   end

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_vld_ff;
   assign rsp.valid_res    = ores_ff;
   assign rsp.finger_count = ofing_ff;
   assign rsp.second_x     = ox_ff;
   assign rsp.second_y     = oy_ff;
   assign rsp.corner_index = oidx_ff;

endmodule

// ----- sim/semi_mt_bitmap_two_touch_tb.sv -----
// ----------------------------------------------------------------------------
// semi_mt_bitmap_two_touch_tb
// drives bitmap reports through the touch decoder under several register
// settings and idle patterns, predicts each held-corner result and compares
// ----------------------------------------------------------------------------
module semi_mt_bitmap_two_touch_tb;
   import semt_pkg::*;

   typedef struct packed {
      logic [MAP_W-1:0]   xmap;
      logic [MAP_W-1:0]   ymap;
      logic [COORD_W-1:0] fx;
      logic [COORD_W-1:0] fy;
      logic               restart;
   } report_type;

   typedef struct packed {
      logic               ok;
      logic [FING_W-1:0]  fingers;
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic [CORN_W-1:0]  corner;
   } corner_type;

   localparam logic [2:0] NO_CORNER = 3'd4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_idx = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   semt_req_if req ();
   semt_rsp_if rsp ();

   semi_mt_bitmap_two_touch DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   // predictor copy of registers and held corner
   logic [COORD_W-1:0] x_max, y_max;
   logic [CNT_W-1:0]   x_cnt, y_cnt;
   logic [MODE_W-1:0]  mirror;
   logic [2:0]         held;

   report_type report_q[$];
   corner_type corner_q[$];
   int errors = 0;
   int send_idle = 0;
   int recv_stall = 0;
   bit in_taken = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #80000000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int run_scan(input logic [MAP_W-1:0] m, output int ls,
                                   output int ll, output int hs, output int hl);
      int runs;
      bit prev;
      int half;
      runs = 0; prev = 0; ls = 0; ll = 0; hs = 0; hl = 0;
      for (int i = 0; i < MAP_W; i++) begin
         if (m[i]) begin
            if (!prev) begin
               runs++;
               if (runs == 1) begin
                  ls = i; ll = 0;
               end else begin
                  hs = i; hl = 0;
               end
            end
            if (runs == 1) ll++;
            else hl++;
         end
         prev = m[i];
      end
      if (runs == 1) begin
         half = ll / 2;
         ll = ll - half;
         hs = ls + half;
         hl = (half > 1) ? half : 1;
      end
      return runs;
   endfunction

   function automatic longint unsigned to_pad(input logic [COORD_W-1:0] maxv,
                                              input logic [CNT_W-1:0] cnt,
                                              input int st, input int len);
      longint unsigned c, v;
      logic [31:0] prod;
      c = (cnt < 2) ? 2 : cnt;
      prod = 32'(maxv) * 32'(2 * st + len - 1);
      v = longint'(prod) / (2 * (c - 1));
      return (v > maxv) ? maxv : v;
   endfunction

   function automatic corner_type predict_corner(input report_type r);
      corner_type res;
      int xls, xll, xhs, xhl, yls, yll, yhs, yhl, nx, ny, best;
      longint unsigned cx[4], cy[4];
      longint dx, dy;
      longint unsigned d, bestd;
      res = '0;
      if (r.restart) held = NO_CORNER;
      if (r.xmap == 0 || r.ymap == 0) return res;
      nx = run_scan(r.xmap, xls, xll, xhs, xhl);
      ny = run_scan(r.ymap, yls, yll, yhs, yhl);
      cx[0] = to_pad(x_max, x_cnt, xls, xll); cx[3] = cx[0];
      cx[1] = to_pad(x_max, x_cnt, xhs, xhl); cx[2] = cx[1];
      cy[0] = to_pad(y_max, y_cnt, yls, yll); cy[1] = cy[0];
      cy[2] = to_pad(y_max, y_cnt, yhs, yhl); cy[3] = cy[2];
      for (int i = 0; i < 4; i++) begin
         if (mirror == MIRROR_X) cx[i] = x_max - cx[i];
         if (mirror == MIRROR_Y) cy[i] = y_max - cy[i];
      end
      if (held == NO_CORNER) begin
         best = 0; bestd = 0;
         for (int i = 0; i < 4; i++) begin
            dx = longint'(r.fx) - longint'(cx[i]);
            dy = longint'(r.fy) - longint'(cy[i]);
            d = dx * dx + dy * dy;
            if (i == 0 || d < bestd) begin
               best = i; bestd = d;
            end
         end
         held = 3'((best + 2) & 3);
      end
      res.ok = 1'b1;
      res.fingers = FING_W'((nx > ny) ? nx : ny);
      res.sx = cx[held[1:0]][COORD_W-1:0];
      res.sy = cy[held[1:0]][COORD_W-1:0];
      res.corner = held[1:0];
      return res;
   endfunction

   // driver: a new beat only once the previous one was taken at the last edge
   always @(negedge clock) begin
      report_type nxt;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || in_taken) begin
         if (report_q.size() > 0 && $urandom_range(99) >= send_idle) begin
            nxt = report_q.pop_front();
            req.valid <= 1'b1;
            {req.x_bitmap, req.y_bitmap, req.first_x, req.first_y, req.restart}
               <= nxt;
         end else begin
            req.valid <= 1'b0;
         end
      end
      rsp.ready <= ($urandom_range(99) >= recv_stall);
   end

   // monitor: prediction at input acceptance, check at output acceptance
   always @(posedge clock) begin
      corner_type got, want;
      report_type rep;
      in_taken <= !reset && req.valid && req.ready;
      if (!reset && req.valid && req.ready) begin
         rep = {req.x_bitmap, req.y_bitmap, req.first_x, req.first_y, req.restart};
         corner_q.push_back(predict_corner(rep));
      end
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.valid_res, rsp.finger_count, rsp.second_x, rsp.second_y,
                rsp.corner_index};
         if (corner_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat %h", $time, got);
         end else begin
            want = corner_q.pop_front();
            if (got.ok !== want.ok)
               $display("%0t: valid_res exp %h got %h", $time, want.ok, got.ok);
            if (got.fingers !== want.fingers)
               $display("%0t: finger_count exp %0d got %0d", $time, want.fingers,
                        got.fingers);
            if (got.sx !== want.sx)
               $display("%0t: second_x exp %0d got %0d", $time, want.sx, got.sx);
            if (got.sy !== want.sy)
               $display("%0t: second_y exp %0d got %0d", $time, want.sy, got.sy);
            if (got.corner !== want.corner)
               $display("%0t: corner_index exp %0d got %0d", $time, want.corner,
                        got.corner);
            if (got !== want) errors++;
         end
      end
   end

   task automatic write_reg(input csr_idx_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_idx <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_X_RANGE_MAX:  x_max = val;
         CSR_Y_RANGE_MAX:  y_max = val;
         CSR_X_SENSOR_CNT: x_cnt = val[CNT_W-1:0];
         CSR_Y_SENSOR_CNT: y_cnt = val[CNT_W-1:0];
         CSR_MIRROR_MODE:  mirror = val[MODE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (report_q.size() > 0 || corner_q.size() > 0 || req.valid)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [MAP_W-1:0] touch_map(input int maxrun);
      logic [MAP_W-1:0] m;
      int st, len;
      m = '0;
      for (int k = $urandom_range(1, maxrun); k > 0; k--) begin
         st = $urandom_range(31);
         len = $urandom_range(1, 6);
         for (int i = st; i < st + len && i < MAP_W; i++) m[i] = 1'b1;
      end
      return m;
   endfunction

   task automatic add(input logic [31:0] xm, input logic [31:0] ym,
                      input logic [15:0] fx, input logic [15:0] fy,
                      input logic rs);
      report_q.push_back({xm, ym, fx, fy, rs});
   endtask

   task automatic random_batch(input int n);
      logic [31:0] xm, ym;
      for (int i = 0; i < n; i++) begin
         xm = touch_map(3); ym = touch_map(3);
         case ($urandom_range(9))
            0: xm = $urandom();
            1: ym = $urandom();
            2: xm = '0;
            3: ym = '0;
            default: ;
         endcase
         add(xm, ym, 16'($urandom()), 16'($urandom()), ($urandom_range(5) == 0));
      end
   endtask

   initial begin
      req.valid = 1'b0; req.x_bitmap = '0; req.y_bitmap = '0;
      req.first_x = '0; req.first_y = '0; req.restart = 1'b0;
      rsp.ready = 1'b0;
      x_max = X_RANGE_RST; y_max = Y_RANGE_RST;
      x_cnt = X_CNT_RST; y_cnt = Y_CNT_RST;
      mirror = MIRROR_NONE; held = NO_CORNER;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty maps, single and split runs, full maps, ties
      add('0, 32'h1, 16'h0, 16'h0, 1'b1);
      add(32'h1, '0, 16'hffff, 16'hffff, 1'b0);
      add(32'h1, 32'h1, 16'h0, 16'h0, 1'b0);
      add(32'h0000_00f0, 32'h0000_0f00, 16'h0, 16'h0, 1'b1);
      add(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 1'b1);
      add(32'h8000_0001, 32'h8000_0001, 16'h800, 16'h800, 1'b1);
      add(32'h5555_5555, 32'haaaa_aaaa, 16'h0, 16'hffff, 1'b1);
      add(32'h8000_0000, 32'h8000_0000, 16'hffff, 16'h0, 1'b1);
      add('0, '0, 16'h1234, 16'h4321, 1'b1);
      add(32'h0000_0c30, 32'h0000_0180, 16'd2047, 16'd2047, 1'b0);
      add(32'h0000_0006, 32'h0000_0006, 16'd2047, 16'd2047, 1'b1);
      drain();

      write_reg(CSR_X_RANGE_MAX, 16'hffff);
      write_reg(CSR_Y_RANGE_MAX, 16'h0000);
      write_reg(CSR_X_SENSOR_CNT, 16'd2);
      write_reg(CSR_Y_SENSOR_CNT, 16'd32);
      write_reg(CSR_MIRROR_MODE, 16'(MIRROR_X));
      add(32'hffff_ffff, 32'h8000_0001, 16'hffff, 16'h0, 1'b1);
      add(32'h0000_0003, 32'h0000_0001, 16'h0, 16'h0, 1'b1);
      random_batch(150);
      drain();

      send_idle = 70;
      write_reg(CSR_X_RANGE_MAX, 16'd1000);
      write_reg(CSR_Y_RANGE_MAX, 16'hffff);
      write_reg(CSR_X_SENSOR_CNT, 16'd32);
      write_reg(CSR_Y_SENSOR_CNT, 16'd0);
      write_reg(CSR_MIRROR_MODE, 16'(MIRROR_Y));
      random_batch(250);
      drain();

      send_idle = 0; recv_stall = 70;
      write_reg(CSR_X_SENSOR_CNT, 16'd63);
      write_reg(CSR_Y_SENSOR_CNT, 16'd1);
      write_reg(CSR_MIRROR_MODE, 16'd3);
      random_batch(250);
      drain();

      send_idle = 18; recv_stall = 18;
      write_reg(CSR_X_RANGE_MAX, 16'd4095);
      write_reg(CSR_Y_RANGE_MAX, 16'd3000);
      write_reg(CSR_X_SENSOR_CNT, 16'd15);
      write_reg(CSR_Y_SENSOR_CNT, 16'd11);
      write_reg(CSR_MIRROR_MODE, 16'(MIRROR_NONE));
      random_batch(330);
      drain();

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/semt_pkg.sv
hw/rtl/semt_req_if.sv
hw/rtl/semt_rsp_if.sv
hw/rtl/semt_scan.sv
hw/rtl/semt_div.sv
hw/rtl/semi_mt_bitmap_two_touch.sv
sim/semi_mt_bitmap_two_touch_tb.sv
